// File: sv/bds_pkg.sv
// Shared types and constants for the power-of-two box downscaler.
package bds_pkg;

    localparam int PIXEL_BITS    = 16;
    localparam int MAX_OUT_WIDTH = 1024;
    localparam int MAX_SHIFT     = 4;

    localparam int SAMPLE_BITS = 16;
    localparam int SUM_BITS    = 24;
    localparam int OUT_BITS    = 16;
    localparam int LANES       = 4;

    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 11;
    localparam int SHIFT_BITS    = 3;
    localparam int WIDTH_BITS    = 11;
    localparam int QUEUE_DEPTH   = 4;

    localparam logic [CFG_IDX_BITS-1:0] CFG_X_SHIFT      = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_Y_SHIFT      = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_OUT_WIDTH    = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ALPHA_ENABLE = 2'd3;

    localparam logic [WIDTH_BITS-1:0] OUT_WIDTH_RESET = 11'd1024;

    // Per-request control decided at intake.
    typedef struct packed {
        logic first;     // overwrite the accumulator entry
        logic emit;      // last pixel of a block: produce a result
        logic row_end;   // last reduced pixel of the output row
        logic alpha_en;
    } t_ctrl;

    localparam int CTRL_BITS = $bits(t_ctrl);

endpackage

// File: sv/bds_front.sv
// Intake: configuration registers, block position counters and request classification.
module bds_front #(
    parameter int PIXEL_BITS    = bds_pkg::PIXEL_BITS,
    parameter int MAX_OUT_WIDTH = bds_pkg::MAX_OUT_WIDTH,
    parameter int MAX_SHIFT     = bds_pkg::MAX_SHIFT,
    localparam int COL_W = $clog2(MAX_OUT_WIDTH),
    localparam int SH_W  = $clog2(2 * MAX_SHIFT + 1)
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_cfg_we,
    input  logic [bds_pkg::CFG_IDX_BITS-1:0]          i_cfg_index,
    input  logic [bds_pkg::CFG_DATA_BITS-1:0]         i_cfg_data,
    input  logic                                      i_accept,
    input  logic [bds_pkg::LANES-1:0][PIXEL_BITS-1:0] i_smp,
    output logic [bds_pkg::LANES-1:0][PIXEL_BITS-1:0] o_smp,
    output logic [COL_W-1:0]                          o_col,
    output logic [SH_W-1:0]                           o_sh,
    output bds_pkg::t_ctrl                            o_ctrl
);

    localparam int XS_W   = $clog2(MAX_SHIFT + 1);
    localparam int SUB_W  = MAX_SHIFT;
    localparam int WID_W  = $clog2(MAX_OUT_WIDTH + 1);
    localparam int CMP_W  = (WID_W > bds_pkg::WIDTH_BITS) ? WID_W : bds_pkg::WIDTH_BITS;

    logic [bds_pkg::SHIFT_BITS-1:0] r_x_shift;
    logic [bds_pkg::SHIFT_BITS-1:0] r_y_shift;
    logic [bds_pkg::WIDTH_BITS-1:0] r_out_width;
    logic                           r_alpha_en;

    logic [SUB_W-1:0] r_sub_col, n_sub_col;
    logic [SUB_W-1:0] r_sub_row, n_sub_row;
    logic [COL_W-1:0] r_out_col, n_out_col;

    logic [XS_W-1:0]    xs, ys;
    logic [SUB_W:0]     xr, yr;
    logic [CMP_W-1:0]   eff_w;
    logic [COL_W-1:0]   col;
    logic               last_col, last_row, last_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_shift   <= '0;
            r_y_shift   <= '0;
            r_out_width <= bds_pkg::OUT_WIDTH_RESET;
            r_alpha_en  <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                bds_pkg::CFG_X_SHIFT:      r_x_shift   <= i_cfg_data[bds_pkg::SHIFT_BITS-1:0];
                bds_pkg::CFG_Y_SHIFT:      r_y_shift   <= i_cfg_data[bds_pkg::SHIFT_BITS-1:0];
                bds_pkg::CFG_OUT_WIDTH:    r_out_width <= i_cfg_data[bds_pkg::WIDTH_BITS-1:0];
                bds_pkg::CFG_ALPHA_ENABLE: r_alpha_en  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        // saturate shifts and clamp the row width
        xs = (r_x_shift > MAX_SHIFT) ? XS_W'(MAX_SHIFT) : XS_W'(r_x_shift);
        ys = (r_y_shift > MAX_SHIFT) ? XS_W'(MAX_SHIFT) : XS_W'(r_y_shift);
        xr = {{SUB_W{1'b0}}, 1'b1} << xs;
        yr = {{SUB_W{1'b0}}, 1'b1} << ys;
        if (r_out_width == '0) begin
            eff_w = CMP_W'(1);
        end else if (CMP_W'(r_out_width) > CMP_W'(MAX_OUT_WIDTH)) begin
            eff_w = CMP_W'(MAX_OUT_WIDTH);
        end else begin
            eff_w = CMP_W'(r_out_width);
        end
        col = (CMP_W'(r_out_col) < CMP_W'(MAX_OUT_WIDTH)) ? r_out_col : '0;

        last_col = ({1'b0, r_sub_col} + 1'b1) >= xr;
        last_row = ({1'b0, r_sub_row} + 1'b1) >= yr;
        last_out = ({1'b0, CMP_W'(col)} + 1'b1) >= {1'b0, eff_w};

        n_sub_col = r_sub_col;
        n_sub_row = r_sub_row;
        n_out_col = r_out_col;
        if (i_accept) begin
            if (last_col) begin
                n_sub_col = '0;
                if (last_out) begin
                    n_out_col = '0;
                    n_sub_row = last_row ? '0 : r_sub_row + 1'b1;
                end else begin
                    n_out_col = col + 1'b1;
                end
            end else begin
                n_sub_col = r_sub_col + 1'b1;
                n_out_col = col;
            end
        end

        o_smp          = i_smp;
        o_col          = col;
        o_sh           = SH_W'(xs) + SH_W'(ys);
        o_ctrl.first   = (r_sub_row == '0) && (r_sub_col == '0);
        o_ctrl.emit    = last_col && last_row;
        o_ctrl.row_end = last_out;
        o_ctrl.alpha_en = r_alpha_en;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sub_col <= '0;
            r_sub_row <= '0;
            r_out_col <= '0;
        end else begin
            r_sub_col <= n_sub_col;
            r_sub_row <= n_sub_row;
            r_out_col <= n_out_col;
        end
    end

endmodule

// File: sv/bds_queue.sv
// Short request queue between intake and the accumulator pipeline.
module bds_queue #(
    parameter int W     = 8,
    parameter int DEPTH = bds_pkg::QUEUE_DEPTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic         o_valid,
    output logic [W-1:0] o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [W-1:0]     r_slot [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            r_count <= r_count + CNT_W'(i_push) - CNT_W'(i_pop);
        end
    end

endmodule

// File: sv/bds_back.sv
// Accumulator row memory, read-modify-write pipeline and result register.
module bds_back #(
    parameter int PIXEL_BITS    = bds_pkg::PIXEL_BITS,
    parameter int MAX_OUT_WIDTH = bds_pkg::MAX_OUT_WIDTH,
    parameter int MAX_SHIFT     = bds_pkg::MAX_SHIFT,
    localparam int COL_W = $clog2(MAX_OUT_WIDTH),
    localparam int SH_W  = $clog2(2 * MAX_SHIFT + 1)
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_req_valid,
    input  logic [bds_pkg::LANES-1:0][PIXEL_BITS-1:0] i_smp,
    input  logic [COL_W-1:0]                          i_col,
    input  logic [SH_W-1:0]                           i_sh,
    input  bds_pkg::t_ctrl                            i_ctrl,
    output logic                                      o_pop,
    output logic                                      o_valid,
    input  logic                                      i_ready,
    output logic [bds_pkg::LANES-1:0][bds_pkg::OUT_BITS-1:0] o_res,
    output logic                                      o_row_end
);

    localparam int SUM_BITS = bds_pkg::SUM_BITS;
    localparam int LANES    = bds_pkg::LANES;

    logic [LANES-1:0][SUM_BITS-1:0] r_mem [MAX_OUT_WIDTH];
    logic [LANES-1:0][SUM_BITS-1:0] r_rdata;

    // accumulate stage
    logic                                 r_b_valid;
    logic [LANES-1:0][PIXEL_BITS-1:0]     r_b_smp;
    logic [COL_W-1:0]                     r_b_col;
    logic [SH_W-1:0]                      r_b_sh;
    bds_pkg::t_ctrl                       r_b_ctrl;
    logic                                 r_fwd_hit;
    logic [LANES-1:0][SUM_BITS-1:0]       r_fwd_sum;

    logic [LANES-1:0][SUM_BITS-1:0]       b_base, b_sum;
    logic [LANES-1:0][SUM_BITS-1:0]       b_shifted;
    logic                                 out_free, b_done;

    assign out_free = !o_valid || i_ready;
    assign b_done   = r_b_valid && (!r_b_ctrl.emit || out_free);
    assign o_pop    = i_req_valid && (!r_b_valid || b_done);

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            // the entry written at the edge of our read is not in r_rdata
            b_base[l] = r_b_ctrl.first ? '0 : (r_fwd_hit ? r_fwd_sum[l] : r_rdata[l]);
            b_sum[l]  = b_base[l] + {{(SUM_BITS - PIXEL_BITS){1'b0}}, r_b_smp[l]};
            b_shifted[l] = b_sum[l] >> r_b_sh;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_done) begin
            r_mem[r_b_col] <= b_sum;
        end
        if (o_pop) begin
            r_rdata <= r_mem[i_col];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_b_smp   <= i_smp;
            r_b_col   <= i_col;
            r_b_sh    <= i_sh;
            r_b_ctrl  <= i_ctrl;
            r_fwd_hit <= b_done && (r_b_col == i_col);
            r_fwd_sum <= b_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (o_pop) begin
            r_b_valid <= 1'b1;
        end else if (b_done) begin
            r_b_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (b_done && r_b_ctrl.emit) begin
            o_valid <= 1'b1;
        end else if (i_ready) begin
            o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_done && r_b_ctrl.emit) begin
            for (int l = 0; l < LANES - 1; l++) begin
                o_res[l] <= b_shifted[l][bds_pkg::OUT_BITS-1:0];
            end
            o_res[LANES-1] <= r_b_ctrl.alpha_en ?
                              b_shifted[LANES-1][bds_pkg::OUT_BITS-1:0] : '0;
            o_row_end <= r_b_ctrl.row_end;
        end
    end

endmodule

// File: sv/box_downscale_pow2.sv
// Top level of the power-of-two box filter image downscaler.
//
//  channel   direction  handshake                   payload
//  pixel in  input      i_in_valid / o_in_ready     i_red i_green i_blue i_alpha
//  result    output     o_out_valid / i_out_ready   o_out_red .. o_out_alpha o_row_end
//  config    input      i_cfg_we (no wait)          i_cfg_index i_cfg_data
//
// One pixel per clock sustained while results are taken; the accumulator memory does one
// read and one write per cycle, with the just-written entry forwarded to the next request.
// A result passes through the request queue and the accumulate stage into the result register.
// Reset is synchronous; the accumulator row is not cleared (a block's first pixel overwrites).
// A stalled result holds the accumulator stage once it holds a block's last pixel; intake
// keeps taking pixels until the four-entry queue fills.
module box_downscale_pow2 #(
    parameter int PIXEL_BITS    = bds_pkg::PIXEL_BITS,
    parameter int MAX_OUT_WIDTH = bds_pkg::MAX_OUT_WIDTH,
    parameter int MAX_SHIFT     = bds_pkg::MAX_SHIFT
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [bds_pkg::CFG_IDX_BITS-1:0]       i_cfg_index,
    input  logic [bds_pkg::CFG_DATA_BITS-1:0]      i_cfg_data,
    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic [bds_pkg::SAMPLE_BITS-1:0]        i_red,
    input  logic [bds_pkg::SAMPLE_BITS-1:0]        i_green,
    input  logic [bds_pkg::SAMPLE_BITS-1:0]        i_blue,
    input  logic [bds_pkg::SAMPLE_BITS-1:0]        i_alpha,
    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic [bds_pkg::OUT_BITS-1:0]           o_out_red,
    output logic [bds_pkg::OUT_BITS-1:0]           o_out_green,
    output logic [bds_pkg::OUT_BITS-1:0]           o_out_blue,
    output logic [bds_pkg::OUT_BITS-1:0]           o_out_alpha,
    output logic                                   o_row_end
);

    localparam int COL_W = $clog2(MAX_OUT_WIDTH);
    localparam int SH_W  = $clog2(2 * MAX_SHIFT + 1);
    localparam int SMP_W = bds_pkg::LANES * PIXEL_BITS;
    localparam int Q_W   = SMP_W + COL_W + SH_W + bds_pkg::CTRL_BITS;

    logic [bds_pkg::LANES-1:0][PIXEL_BITS-1:0] in_smp, f_smp, q_smp;
    logic [COL_W-1:0]     f_col, q_col;
    logic [SH_W-1:0]      f_sh, q_sh;
    bds_pkg::t_ctrl       f_ctrl, q_ctrl;
    logic [Q_W-1:0]       q_in, q_out;
    logic                 q_full, q_valid, q_pop, accept;
    logic [bds_pkg::LANES-1:0][bds_pkg::OUT_BITS-1:0] res;

    assign in_smp = {i_alpha[PIXEL_BITS-1:0], i_blue[PIXEL_BITS-1:0],
                     i_green[PIXEL_BITS-1:0], i_red[PIXEL_BITS-1:0]};
    assign o_in_ready = !q_full;
    assign accept     = i_in_valid && o_in_ready;

    bds_front #(
        .PIXEL_BITS(PIXEL_BITS), .MAX_OUT_WIDTH(MAX_OUT_WIDTH), .MAX_SHIFT(MAX_SHIFT)
    ) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_accept(accept), .i_smp(in_smp),
        .o_smp(f_smp), .o_col(f_col), .o_sh(f_sh), .o_ctrl(f_ctrl)
    );

    assign q_in = {f_ctrl, f_sh, f_col, f_smp};
    assign {q_ctrl, q_sh, q_col, q_smp} = q_out;

    bds_queue #(.W(Q_W), .DEPTH(bds_pkg::QUEUE_DEPTH)) u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(accept), .i_data(q_in), .o_full(q_full),
        .i_pop(q_pop), .o_valid(q_valid), .o_data(q_out)
    );

    bds_back #(
        .PIXEL_BITS(PIXEL_BITS), .MAX_OUT_WIDTH(MAX_OUT_WIDTH), .MAX_SHIFT(MAX_SHIFT)
    ) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_req_valid(q_valid), .i_smp(q_smp), .i_col(q_col), .i_sh(q_sh),
        .i_ctrl(q_ctrl), .o_pop(q_pop),
        .o_valid(o_out_valid), .i_ready(i_out_ready),
        .o_res(res), .o_row_end(o_row_end)
    );

    assign o_out_red   = res[0];
    assign o_out_green = res[1];
    assign o_out_blue  = res[2];
    assign o_out_alpha = res[3];

endmodule

// File: sv/bds_checker.sv
// Port-level checker for the box downscaler, bound to the top level.
module bds_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              o_in_ready,
    input logic                              o_out_valid,
    input logic                              i_out_ready,
    input logic [bds_pkg::OUT_BITS-1:0]      o_out_red,
    input logic [bds_pkg::OUT_BITS-1:0]      o_out_alpha,
    input logic                              o_row_end
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            $stable(o_out_red) && $stable(o_out_alpha) && $stable(o_row_end))
        else $error("stalled result changed");

    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_reset_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_ready)
        else $error("intake not ready after reset");

endmodule

bind box_downscale_pow2 bds_checker u_bds_checker (.*);

// File: bench/bds_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the box downscaler: mirrors the accumulator row and checks every result.
module bds_scoreboard (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [bds_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [bds_pkg::CFG_DATA_BITS-1:0] i_cfg_data,
    input  logic                              i_in_valid,
    input  logic                              i_in_ready,
    input  logic [bds_pkg::SAMPLE_BITS-1:0]   i_red,
    input  logic [bds_pkg::SAMPLE_BITS-1:0]   i_green,
    input  logic [bds_pkg::SAMPLE_BITS-1:0]   i_blue,
    input  logic [bds_pkg::SAMPLE_BITS-1:0]   i_alpha,
    input  logic                              i_out_valid,
    input  logic                              i_out_ready,
    input  logic [bds_pkg::OUT_BITS-1:0]      i_out_red,
    input  logic [bds_pkg::OUT_BITS-1:0]      i_out_green,
    input  logic [bds_pkg::OUT_BITS-1:0]      i_out_blue,
    input  logic [bds_pkg::OUT_BITS-1:0]      i_out_alpha,
    input  logic                              i_row_end,
    output int                                o_mismatches,
    output int                                o_pending,
    output int                                o_results
);

    localparam int PIXEL_BITS    = bds_pkg::PIXEL_BITS;
    localparam int MAX_OUT_WIDTH = bds_pkg::MAX_OUT_WIDTH;
    localparam int MAX_SHIFT     = bds_pkg::MAX_SHIFT;
    localparam int SAMPLE_BITS   = bds_pkg::SAMPLE_BITS;
    localparam int SUM_BITS      = bds_pkg::SUM_BITS;
    localparam int OUT_BITS      = bds_pkg::OUT_BITS;
    localparam int LANES         = bds_pkg::LANES;
    localparam int SHIFT_BITS    = bds_pkg::SHIFT_BITS;
    localparam int WIDTH_BITS    = bds_pkg::WIDTH_BITS;

    localparam int LANE_RED     = 0;
    localparam int LANE_GREEN   = 1;
    localparam int LANE_BLUE    = 2;
    localparam int LANE_ALPHA   = 3;
    localparam int REPORT_LIMIT = 10;
    localparam int COL_BITS     = $clog2(MAX_OUT_WIDTH);

    typedef struct packed {
        logic [OUT_BITS-1:0] red;
        logic [OUT_BITS-1:0] green;
        logic [OUT_BITS-1:0] blue;
        logic [OUT_BITS-1:0] alpha;
        logic                row_end;
    } t_reduced;

    logic [SHIFT_BITS-1:0] x_shift_reg;
    logic [SHIFT_BITS-1:0] y_shift_reg;
    logic [WIDTH_BITS-1:0] width_reg;
    logic                  alpha_reg;

    logic [MAX_SHIFT-1:0]  sub_col;
    logic [COL_BITS-1:0]   out_col;
    logic [MAX_SHIFT-1:0]  sub_row;

    logic [SUM_BITS-1:0]   acc_row [LANES][MAX_OUT_WIDTH];
    t_reduced              reduced_q [$];
    int                    mismatches = 0;
    int                    results = 0;

    // Add one full-size pixel into its column sum; queue the average when a block closes.
    task automatic accumulate_pixel(input logic [LANES-1:0][SAMPLE_BITS-1:0] smp);
        int       xs;
        int       ys;
        int       width;
        int       col;
        int       sh;
        logic     is_first;
        logic     col_done;
        logic     row_done;
        logic     line_done;
        t_reduced avg;
        xs = (int'(x_shift_reg) > MAX_SHIFT) ? MAX_SHIFT : int'(x_shift_reg);
        ys = (int'(y_shift_reg) > MAX_SHIFT) ? MAX_SHIFT : int'(y_shift_reg);
        if (width_reg == '0) begin
            width = 1;
        end else if (int'(width_reg) > MAX_OUT_WIDTH) begin
            width = MAX_OUT_WIDTH;
        end else begin
            width = int'(width_reg);
        end
        col       = int'(out_col);
        is_first  = (sub_row == '0) && (sub_col == '0);
        col_done  = (int'(sub_col) + 1) >= (1 << xs);
        row_done  = (int'(sub_row) + 1) >= (1 << ys);
        line_done = (col + 1) >= width;

        // The first pixel of a block overwrites the entry instead of adding to it.
        for (int l = 0; l < LANES; l++) begin
            acc_row[l][col] = (is_first ? {SUM_BITS{1'b0}} : acc_row[l][col])
                              + SUM_BITS'(smp[l][PIXEL_BITS-1:0]);
        end

        if (col_done && row_done) begin
            sh          = xs + ys;
            avg.red     = OUT_BITS'(acc_row[LANE_RED][col] >> sh);
            avg.green   = OUT_BITS'(acc_row[LANE_GREEN][col] >> sh);
            avg.blue    = OUT_BITS'(acc_row[LANE_BLUE][col] >> sh);
            avg.alpha   = alpha_reg ? OUT_BITS'(acc_row[LANE_ALPHA][col] >> sh) : '0;
            avg.row_end = line_done;
            reduced_q.push_back(avg);
        end

        // Counters past a freshly lowered bound wrap at their next advance.
        if (col_done) begin
            sub_col = '0;
            if (line_done) begin
                out_col = '0;
                sub_row = row_done ? '0 : sub_row + 1'b1;
            end else begin
                out_col = out_col + 1'b1;
            end
        end else begin
            sub_col = sub_col + 1'b1;
        end
    endtask

    task automatic flag_result(input string what, input t_reduced want, input t_reduced got);
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
            $display("%s at result %0d: expected r=%h g=%h b=%h a=%h end=%b",
                     what, results, want.red, want.green, want.blue, want.alpha, want.row_end);
            $display("    got r=%h g=%h b=%h a=%h end=%b",
                     got.red, got.green, got.blue, got.alpha, got.row_end);
        end
    endtask

    always @(posedge i_clk) begin
        t_reduced got;
        t_reduced want;
        if (!i_rst_n) begin
            x_shift_reg = '0;
            y_shift_reg = '0;
            width_reg   = bds_pkg::OUT_WIDTH_RESET;
            alpha_reg   = 1'b0;
            sub_col     = '0;
            out_col     = '0;
            sub_row     = '0;
            reduced_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    bds_pkg::CFG_X_SHIFT:      x_shift_reg = i_cfg_data[SHIFT_BITS-1:0];
                    bds_pkg::CFG_Y_SHIFT:      y_shift_reg = i_cfg_data[SHIFT_BITS-1:0];
                    bds_pkg::CFG_OUT_WIDTH:    width_reg   = i_cfg_data[WIDTH_BITS-1:0];
                    bds_pkg::CFG_ALPHA_ENABLE: alpha_reg   = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                accumulate_pixel({i_alpha, i_blue, i_green, i_red});
            end
            if (i_out_valid && i_out_ready) begin
                got.red     = i_out_red;
                got.green   = i_out_green;
                got.blue    = i_out_blue;
                got.alpha   = i_out_alpha;
                got.row_end = i_row_end;
                results++;
                if (reduced_q.size() == 0) begin
                    flag_result("result with no request pending", '0, got);
                end else begin
                    want = reduced_q.pop_front();
                    if (got.red !== want.red || got.green !== want.green
                        || got.blue !== want.blue || got.alpha !== want.alpha
                        || got.row_end !== want.row_end) begin
                        flag_result("mismatch", want, got);
                    end
                end
            end
        end
        o_pending    <= reduced_q.size();
        o_mismatches <= mismatches;
        o_results    <= results;
    end

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// Testbench top for the box downscaler: clock, reset, pixel and register stimulus, verdict.
module tb_top;

    localparam int CFG_IDX_BITS  = bds_pkg::CFG_IDX_BITS;
    localparam int CFG_DATA_BITS = bds_pkg::CFG_DATA_BITS;
    localparam int SAMPLE_BITS   = bds_pkg::SAMPLE_BITS;
    localparam int OUT_BITS      = bds_pkg::OUT_BITS;
    localparam int SHIFT_BITS    = bds_pkg::SHIFT_BITS;
    localparam int WIDTH_BITS    = bds_pkg::WIDTH_BITS;
    localparam int MAX_SHIFT     = bds_pkg::MAX_SHIFT;
    localparam int MAX_OUT_WIDTH = bds_pkg::MAX_OUT_WIDTH;

    localparam int RESET_CYCLES  = 7;
    localparam int SETTLE_CYCLES = 16;
    localparam int STALL_LIMIT   = 2000;
    localparam int TOTAL_PIXELS  = 1600;
    localparam int PACE_SPAN     = 100;
    localparam int WIDTH_MAX_REG = (1 << WIDTH_BITS) - 1;

    typedef enum int {PACE_FREE, PACE_SEND_GAPS, PACE_RECV_STALLS, PACE_BOTH} t_pace;

    logic                     i_clk       = 1'b0;
    logic                     i_rst_n     = 1'b0;
    logic                     i_cfg_we    = 1'b0;
    logic [CFG_IDX_BITS-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] i_cfg_data  = '0;
    logic                     i_in_valid  = 1'b0;
    logic [SAMPLE_BITS-1:0]   i_red       = '0;
    logic [SAMPLE_BITS-1:0]   i_green     = '0;
    logic [SAMPLE_BITS-1:0]   i_blue      = '0;
    logic [SAMPLE_BITS-1:0]   i_alpha     = '0;
    logic                     i_out_ready = 1'b0;
    logic                     o_in_ready;
    logic                     o_out_valid;
    logic [OUT_BITS-1:0]      o_out_red;
    logic [OUT_BITS-1:0]      o_out_green;
    logic [OUT_BITS-1:0]      o_out_blue;
    logic [OUT_BITS-1:0]      o_out_alpha;
    logic                     o_row_end;

    int send_idle    = 0;
    int recv_idle    = 0;
    int stall_cycles = 0;
    int pixels_sent  = 0;
    int settings_run = 0;
    int mismatches;
    int pending;
    int results;

    always #10 i_clk = ~i_clk;

    box_downscale_pow2 dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_red       (i_red),
        .i_green     (i_green),
        .i_blue      (i_blue),
        .i_alpha     (i_alpha),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_red   (o_out_red),
        .o_out_green (o_out_green),
        .o_out_blue  (o_out_blue),
        .o_out_alpha (o_out_alpha),
        .o_row_end   (o_row_end)
    );

    bds_scoreboard u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_red        (i_red),
        .i_green      (i_green),
        .i_blue       (i_blue),
        .i_alpha      (i_alpha),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out_red    (o_out_red),
        .i_out_green  (o_out_green),
        .i_out_blue   (o_out_blue),
        .i_out_alpha  (o_out_alpha),
        .i_row_end    (o_row_end),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_results    (results)
    );

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_idle);
    end

    // Abort when neither channel moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no request moved in %0d cycles", STALL_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic set_pace(input t_pace pace);
        case (pace)
            PACE_FREE:        begin send_idle = 0;  recv_idle = 0;  end
            PACE_SEND_GAPS:   begin send_idle = 54; recv_idle = 0;  end
            PACE_RECV_STALLS: begin send_idle = 0;  recv_idle = 54; end
            default:          begin send_idle = 21; recv_idle = 21; end
        endcase
    endtask

    // Offer one pixel, after an optional gap, and hold it until it is taken.
    task automatic push_pixel(input logic [SAMPLE_BITS-1:0] r, input logic [SAMPLE_BITS-1:0] g,
                              input logic [SAMPLE_BITS-1:0] b, input logic [SAMPLE_BITS-1:0] a);
        // rotate through the four pacing mixes as pixels go out
        if (pixels_sent % PACE_SPAN == 0) begin
            set_pace(t_pace'((pixels_sent / PACE_SPAN) % 4));
        end
        while ($urandom_range(99) < send_idle) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_red      <= r;
        i_green    <= g;
        i_blue     <= b;
        i_alpha    <= a;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        pixels_sent++;
    endtask

    // Hold the sender until every queued result is out and the pipeline has drained.
    task automatic quiesce();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
    endtask

    // Unused upper data bits carry noise; the block must ignore them.
    task automatic set_config(input int xs, input int ys, input int w, input int ae);
        logic [CFG_DATA_BITS-1:0] word;
        word = CFG_DATA_BITS'($urandom);
        word[SHIFT_BITS-1:0] = SHIFT_BITS'(xs);
        write_reg(bds_pkg::CFG_X_SHIFT, word);
        word = CFG_DATA_BITS'($urandom);
        word[SHIFT_BITS-1:0] = SHIFT_BITS'(ys);
        write_reg(bds_pkg::CFG_Y_SHIFT, word);
        write_reg(bds_pkg::CFG_OUT_WIDTH, CFG_DATA_BITS'(w));
        word = CFG_DATA_BITS'($urandom);
        word[0] = ae[0];
        write_reg(bds_pkg::CFG_ALPHA_ENABLE, word);
        i_cfg_we <= 1'b0;
        settings_run++;
    endtask

    function automatic int pick_shift();
        int r;
        r = $urandom_range(19);
        if (r < 8) return 0;
        if (r < 13) return 1;
        if (r < 16) return 2;
        if (r < 18) return $urandom_range(MAX_SHIFT, 3);
        return $urandom_range((1 << SHIFT_BITS) - 1, MAX_SHIFT + 1);
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] rand_sample();
        case ($urandom_range(5))
            0:       return '0;
            1:       return '1;
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    // One setting, then whole block rows of random pixels so every block closes.
    task automatic run_phase(input int xs, input int ys, input int w, input int ae,
                             input int max_rows);
        int xe;
        int ye;
        int we_eff;
        int cost;
        int rows;
        quiesce();
        set_config(xs, ys, w, ae);
        xe     = (xs > MAX_SHIFT) ? MAX_SHIFT : xs;
        ye     = (ys > MAX_SHIFT) ? MAX_SHIFT : ys;
        we_eff = (w == 0) ? 1 : ((w > MAX_OUT_WIDTH) ? MAX_OUT_WIDTH : w);
        cost   = we_eff << (xe + ye);
        rows   = (cost <= 64) ? 4 : ((cost <= 256) ? 2 : 1);
        if (rows > max_rows) rows = max_rows;
        rows   = $urandom_range(rows, 1);
        for (int r = 0; r < rows; r++) begin
            if (r > 0 && $urandom_range(3) == 0) quiesce();
            for (int p = 0; p < cost; p++) begin
                push_pixel(rand_sample(), rand_sample(), rand_sample(), rand_sample());
            end
        end
    endtask

    initial begin
        int xs;
        int ys;
        int xe;
        int ye;
        int wmax;
        int w;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: one pixel per block, alpha disabled, widest row.
        push_pixel(16'h0000, 16'h0000, 16'h0000, 16'h0000);
        push_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        push_pixel(16'hAAAA, 16'h5555, 16'h0F0F, 16'hF0F0);
        push_pixel(16'h5555, 16'hAAAA, 16'hF0F0, 16'h0F0F);

        // Narrow the row while the column counter sits past the new bound.
        quiesce();
        set_config(0, 0, 2, 1);
        push_pixel(16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0);
        push_pixel(16'hFFFF, 16'h0001, 16'h8000, 16'h7FFF);
        push_pixel(16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF);

        // Saturated horizontal shift with a zero width: one full-scale 16-pixel block.
        quiesce();
        set_config((1 << SHIFT_BITS) - 1, 0, 0, 1);
        repeat (1 << MAX_SHIFT) push_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);

        // Extremes: clamped widest row, and the largest block.
        run_phase(0, 0, WIDTH_MAX_REG, 0, 1);
        run_phase(MAX_SHIFT, (1 << SHIFT_BITS) - 1, 1, 1, 1);

        while (pixels_sent < TOTAL_PIXELS) begin
            xs   = pick_shift();
            ys   = pick_shift();
            xe   = (xs > MAX_SHIFT) ? MAX_SHIFT : xs;
            ye   = (ys > MAX_SHIFT) ? MAX_SHIFT : ys;
            wmax = MAX_OUT_WIDTH >> (xe + ye);
            case ($urandom_range(9))
                0: w = 0;
                1: w = (wmax == MAX_OUT_WIDTH) ? $urandom_range(WIDTH_MAX_REG, MAX_OUT_WIDTH)
                                               : wmax;
                2: w = $urandom_range((wmax < 64) ? wmax : 64, 1);
                default: w = $urandom_range((wmax < 8) ? wmax : 8, 1);
            endcase
            run_phase(xs, ys, w, $urandom_range(1), 4);
        end

        quiesce();
        $display("Sent %0d pixels over %0d register settings, with saturated shifts,",
                 pixels_sent, settings_run);
        $display("odd widths, a mid-row width change and all four pacing mixes; %0d results.",
                 results);
        if (mismatches == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// File: sim.f
sv/bds_pkg.sv
sv/bds_front.sv
sv/bds_queue.sv
sv/bds_back.sv
sv/box_downscale_pow2.sv
sv/bds_checker.sv
bench/bds_checker.sv
bench/tb_top.sv
